@@ rtl/symmetric3_jacobi_eigen_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Jacobi eigen unit assertion macros
// Shared property wrappers for the checker of the eigen unit.
// ----------------------------------------------------------------------------
`ifndef SYMMETRIC3_JACOBI_EIGEN_UNIT_ASSERT_SVH
`define SYMMETRIC3_JACOBI_EIGEN_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SJE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eigen unit check failed");

// Next-cycle implication, disabled while reset is low.
`define SJE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eigen unit check failed");

`endif

@@ rtl/sje_pkg.sv @@
// ----------------------------------------------------------------------------
// Jacobi eigen unit package
// Widths, constants, pair table, microcode and output helpers.
// ----------------------------------------------------------------------------
package sje_pkg;

  // Datapath widths.
  localparam int ENT_W  = 35;  // matrix entries, Q.16, saturated to +-2^33
  localparam int VEC_W  = 31;  // eigenvector entries, Q.28, saturated to +-2^29
  localparam int CS_W   = 30;  // cos, sin and their products, Q.28
  localparam int CX_W   = 38;  // CORDIC x and y
  localparam int CZ_W   = 36;  // CORDIC angle, Q.30
  localparam int SUM_W  = 36;  // absolute sum and multiplier B operand
  localparam int PROD_W = 66;
  localparam int ACC_W  = 68;
  localparam int RES_W  = 40;  // rounded accumulator
  localparam int TS_W   = 52;  // tolerance times sum

  localparam logic signed [CZ_W-1:0] PI_Q30   = 36'sd3373259426;
  localparam logic signed [CX_W-1:0] GAIN_Q30 = 38'sd652032874;
  localparam logic signed [RES_W-1:0] ENT_LIM = 40'sd8589934592;
  localparam logic signed [RES_W-1:0] VEC_LIM = 40'sd536870912;

  // Configuration register indexes.
  localparam logic REG_MAX_SWEEPS = 1'b0;
  localparam logic REG_REL_TOL    = 1'b1;

  // Multiplier A operand selects.
  localparam logic [2:0] A_C   = 3'd0;
  localparam logic [2:0] A_S   = 3'd1;
  localparam logic [2:0] A_C2  = 3'd2;
  localparam logic [2:0] A_S2  = 3'd3;
  localparam logic [2:0] A_CS  = 3'd4;
  localparam logic [2:0] A_TOL = 3'd5;

  // Multiplier B operand selects.
  localparam logic [3:0] B_C   = 4'd0;
  localparam logic [3:0] B_S   = 4'd1;
  localparam logic [3:0] B_APP = 4'd2;
  localparam logic [3:0] B_AQQ = 4'd3;
  localparam logic [3:0] B_APQ = 4'd4;
  localparam logic [3:0] B_ARP = 4'd5;
  localparam logic [3:0] B_ARQ = 4'd6;
  localparam logic [3:0] B_VP  = 4'd7;
  localparam logic [3:0] B_VQ  = 4'd8;
  localparam logic [3:0] B_SUM = 4'd9;

  // Writeback codes.
  localparam logic [2:0] WB_NONE = 3'd0;
  localparam logic [2:0] WB_C2   = 3'd1;
  localparam logic [2:0] WB_S2   = 3'd2;
  localparam logic [2:0] WB_CS   = 3'd3;
  localparam logic [2:0] WB_TMP  = 3'd4;
  localparam logic [2:0] WB_DQ   = 3'd5;
  localparam logic [2:0] WB_ORQ  = 3'd6;
  localparam logic [2:0] WB_VQ   = 3'd7;

  localparam logic [4:0] MOP_LAST = 5'd24;

  typedef struct packed {
    logic [1:0] p;
    logic [1:0] q;
    logic [1:0] opq;
    logic [1:0] orp;
    logic [1:0] orq;
  } pair_t;

  typedef struct packed {
    logic [2:0] a_sel;
    logic [3:0] b_sel;
    logic       first;
    logic       neg;
    logic       dbl;
    logic [2:0] wb;
    logic [1:0] vk;
  } mop_t;

  // Pair index: 0 is a01, 1 is a02, 2 is a12 (stored off-diagonal 0 is a01, 1 is a12, 2 is a02).
  function automatic pair_t pair_info(input logic [1:0] pr);
    pair_t r;
    case (pr)
      2'd0:    r = '{p: 2'd0, q: 2'd1, opq: 2'd0, orp: 2'd2, orq: 2'd1};
      2'd1:    r = '{p: 2'd0, q: 2'd2, opq: 2'd2, orp: 2'd0, orq: 2'd1};
      default: r = '{p: 2'd1, q: 2'd2, opq: 2'd1, orp: 2'd0, orq: 2'd2};
    endcase
    return r;
  endfunction

  // One rotation as a list of multiply-accumulate steps.
  function automatic mop_t mop_get(input logic [4:0] u);
    mop_t m;
    logic [4:0] w;
    m = '{a_sel: A_C, b_sel: B_C, first: 1'b1, neg: 1'b0, dbl: 1'b0,
          wb: WB_NONE, vk: 2'd0};
    w = u - 5'd13;
    case (u)
      5'd0:  begin m.wb = WB_C2; end
      5'd1:  begin m.a_sel = A_S; m.b_sel = B_S; m.wb = WB_S2; end
      5'd2:  begin m.b_sel = B_S; m.wb = WB_CS; end
      5'd3:  begin m.a_sel = A_C2; m.b_sel = B_APP; end
      5'd4:  begin m.a_sel = A_CS; m.b_sel = B_APQ; m.first = 1'b0; m.dbl = 1'b1; end
      5'd5:  begin
        m.a_sel = A_S2; m.b_sel = B_AQQ; m.first = 1'b0; m.wb = WB_TMP;
      end
      5'd6:  begin m.a_sel = A_S2; m.b_sel = B_APP; end
      5'd7:  begin
        m.a_sel = A_CS; m.b_sel = B_APQ; m.first = 1'b0; m.dbl = 1'b1; m.neg = 1'b1;
      end
      5'd8:  begin
        m.a_sel = A_C2; m.b_sel = B_AQQ; m.first = 1'b0; m.wb = WB_DQ;
      end
      5'd9:  begin m.b_sel = B_ARP; end
      5'd10: begin m.a_sel = A_S; m.b_sel = B_ARQ; m.first = 1'b0; m.wb = WB_TMP; end
      5'd11: begin m.b_sel = B_ARQ; end
      5'd12: begin
        m.a_sel = A_S; m.b_sel = B_ARP; m.first = 1'b0; m.neg = 1'b1; m.wb = WB_ORQ;
      end
      default: begin
        // Eigenvector rows, four steps per row.
        m.vk = w[3:2];
        case (w[1:0])
          2'd0: begin m.b_sel = B_VP; end
          2'd1: begin
            m.a_sel = A_S; m.b_sel = B_VQ; m.first = 1'b0; m.wb = WB_TMP;
          end
          2'd2: begin m.b_sel = B_VQ; end
          default: begin
            m.a_sel = A_S; m.b_sel = B_VP; m.first = 1'b0; m.neg = 1'b1;
            m.wb = WB_VQ;
          end
        endcase
      end
    endcase
    return m;
  endfunction

  // Arctangent of 2^-i in Q.30.
  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] r;
    r = '0;
    case (i)
      5'd0:  r = 31'd843314857;
      5'd1:  r = 31'd497837829;
      5'd2:  r = 31'd263043837;
      5'd3:  r = 31'd133525159;
      5'd4:  r = 31'd67021687;
      5'd5:  r = 31'd33543516;
      5'd6:  r = 31'd16775851;
      5'd7:  r = 31'd8388437;
      5'd8:  r = 31'd4194283;
      5'd9:  r = 31'd2097149;
      5'd31: r = '0;
      default: r[5'd30 - i] = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic signed [ENT_W-1:0] clamp_entry(
      input logic signed [RES_W-1:0] x);
    logic signed [RES_W-1:0] r;
    r = x;
    if (x > ENT_LIM) r = ENT_LIM;
    if (x < -ENT_LIM) r = -ENT_LIM;
    return r[ENT_W-1:0];
  endfunction

  function automatic logic signed [VEC_W-1:0] clamp_vec(
      input logic signed [RES_W-1:0] x);
    logic signed [RES_W-1:0] r;
    r = x;
    if (x > VEC_LIM) r = VEC_LIM;
    if (x < -VEC_LIM) r = -VEC_LIM;
    return r[VEC_W-1:0];
  endfunction

  // Eigenvalue saturated to the 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [ENT_W-1:0] d);
    logic signed [31:0] r;
    r = d[31:0];
    if (d > 35'sd2147483647) r = 32'sh7FFFFFFF;
    if (d < -35'sd2147483648) r = 32'sh80000000;
    return r;
  endfunction

  // Q.28 vector entry rounded to Q1.16 and saturated to +-1.0.
  function automatic logic signed [17:0] vec_out(input logic signed [VEC_W-1:0] v);
    logic signed [31:0] t;
    t = (32'(v) + 32'sd2048) >>> 12;
    if (t > 32'sd65536) t = 32'sd65536;
    if (t < -32'sd65536) t = -32'sd65536;
    return t[17:0];
  endfunction

endpackage

@@ rtl/symmetric3_jacobi_eigen_unit.sv @@
// Sequence: a tolerance setup step, then per sweep a test of each pair and a rotation
// where needed, then a bubble sort and 3 output words.
// Matrices are taken one at a time; a rotation costs two CORDIC passes and 25
// steps of the single shared multiply-accumulate unit.
// Reset: synchronous, active low; registers return to 50 sweeps and tolerance 66,
// the sequencer returns to idle and any pending output word is dropped.
// ----------------------------------------------------------------------------
// Symmetric 3x3 Jacobi eigen unit
// Cyclic Jacobi rotations with a shared CORDIC and multiplier, then a sort and
// three eigenpair output words.
// ----------------------------------------------------------------------------
module symmetric3_jacobi_eigen_unit #(
  parameter int CORDIC_STEPS = 18
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,   // a00, a11, a22, a01, a12, a02 (32 bit each)
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata,  // pair_index(2), eigenvalue(32), vec_x, vec_y, vec_z(18)
  output logic         out_tlast,  // last_pair
  output logic [0:0]   out_tuser   // not_converged
);

  localparam int IW = $clog2(CORDIC_STEPS);
  localparam logic [IW-1:0] ITER_LAST = IW'(CORDIC_STEPS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TOL   = 4'd1;
  localparam logic [3:0] S_PAIR  = 4'd2;
  localparam logic [3:0] S_VEC   = 4'd3;
  localparam logic [3:0] S_RINIT = 4'd4;
  localparam logic [3:0] S_ROT   = 4'd5;
  localparam logic [3:0] S_CS    = 4'd6;
  localparam logic [3:0] S_MAC   = 4'd7;
  localparam logic [3:0] S_SWEEP = 4'd8;
  localparam logic [3:0] S_SORT  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_r;
  logic [7:0] max_sweeps_r;
  logic [15:0] rel_tol_r;

  logic signed [sje_pkg::ENT_W-1:0] d_r [3];
  logic signed [sje_pkg::ENT_W-1:0] o_r [3];
  logic signed [sje_pkg::VEC_W-1:0] v_r [3][3];

  logic [sje_pkg::SUM_W-1:0] sum_r;
  logic [sje_pkg::TS_W-1:0]  tolsum_r;
  logic [sje_pkg::SUM_W-1:0] ssum_r;
  logic [7:0] sweeps_r;
  logic [1:0] pr_r;
  logic [IW-1:0] iter_r;
  logic signed [sje_pkg::CX_W-1:0] cx_r, cy_r;
  logic signed [sje_pkg::CZ_W-1:0] cz_r;
  logic signed [sje_pkg::CS_W-1:0] c_r, s_r, c2_r, s2_r, cs_r;
  logic [4:0] u_r;
  logic [1:0] ph_r;
  logic signed [sje_pkg::PROD_W-1:0] prod_r;
  logic signed [sje_pkg::ACC_W-1:0]  acc_r;
  logic signed [sje_pkg::RES_W-1:0]  tmp_r;
  logic nc_r;
  logic [1:0] k_r;
  logic [1:0] sort_r;

  logic out_tvalid_r;
  logic [1:0] out_idx_r;
  logic signed [31:0] out_ev_r;
  logic signed [17:0] out_vx_r, out_vy_r, out_vz_r;
  logic out_nc_r, out_last_r;

  // Pair and microcode decode.
  sje_pkg::pair_t pi;
  sje_pkg::mop_t  mop;
  assign pi  = sje_pkg::pair_info(pr_r);
  assign mop = sje_pkg::mop_get(u_r);

  // Absolute sum of the incoming matrix, off-diagonals counted twice.
  logic [32:0] in_abs [6];
  logic [sje_pkg::SUM_W-1:0] in_sum;
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      in_abs[i] = in_tdata[32*i+31] ? 33'(-$signed({1'b1, in_tdata[32*i +: 32]}))
                                    : {1'b0, in_tdata[32*i +: 32]};
    end
    in_sum = 36'(in_abs[0]) + 36'(in_abs[1]) + 36'(in_abs[2])
           + ((36'(in_abs[3]) + 36'(in_abs[4]) + 36'(in_abs[5])) << 1);
  end

  // Rotation test for the current pair and the end-of-sweep test.
  logic [sje_pkg::ENT_W-1:0] off_abs;
  logic rot_need, sweep_done;
  logic [7:0] sweeps_nxt;
  assign off_abs    = o_r[pi.opq][sje_pkg::ENT_W-1] ? -o_r[pi.opq] : o_r[pi.opq];
  assign rot_need   = sje_pkg::TS_W'({off_abs, 16'd0}) > tolsum_r;
  assign sweep_done = {ssum_r, 16'd0} <= tolsum_r;
  assign sweeps_nxt = sweeps_r + 8'd1;

  // Starting vector for the angle search, pre-rotated by pi when x is negative.
  logic signed [sje_pkg::CX_W-1:0] vx0, vy0;
  assign vx0 = sje_pkg::CX_W'(d_r[pi.p]) - sje_pkg::CX_W'(d_r[pi.q]);
  assign vy0 = sje_pkg::CX_W'(o_r[pi.opq]) <<< 1;

  // Shared CORDIC micro-rotation, vectoring or rotating.
  logic signed [sje_pkg::CX_W-1:0] sh_x, sh_y, cx_nxt, cy_nxt;
  logic signed [sje_pkg::CZ_W-1:0] at_s, cz_nxt;
  logic sigma;
  always_comb begin
    sh_x  = cx_r >>> iter_r;
    sh_y  = cy_r >>> iter_r;
    at_s  = sje_pkg::CZ_W'(sje_pkg::atan_q30(5'(iter_r)));
    sigma = (state_r == S_VEC) ? (cy_r > 0) : cz_r[sje_pkg::CZ_W-1];
    if (sigma) begin
      cx_nxt = cx_r + sh_y;
      cy_nxt = cy_r - sh_x;
      cz_nxt = cz_r + at_s;
    end else begin
      cx_nxt = cx_r - sh_y;
      cy_nxt = cy_r + sh_x;
      cz_nxt = cz_r - at_s;
    end
  end

  // cos and sin rounded from Q.30 to Q.28.
  logic signed [sje_pkg::CX_W-1:0] c_full, s_full;
  assign c_full = (cx_r + 38'sd2) >>> 2;
  assign s_full = (cy_r + 38'sd2) >>> 2;

  // Multiplier operand selection.
  logic [2:0] a_sel;
  logic [3:0] b_sel;
  logic signed [sje_pkg::CS_W-1:0]  a_op;
  logic signed [sje_pkg::SUM_W-1:0] b_op;
  always_comb begin
    a_sel = (state_r == S_TOL) ? sje_pkg::A_TOL : mop.a_sel;
    b_sel = (state_r == S_TOL) ? sje_pkg::B_SUM : mop.b_sel;
    case (a_sel)
      sje_pkg::A_C:   a_op = c_r;
      sje_pkg::A_S:   a_op = s_r;
      sje_pkg::A_C2:  a_op = c2_r;
      sje_pkg::A_S2:  a_op = s2_r;
      sje_pkg::A_CS:  a_op = cs_r;
      sje_pkg::A_TOL: a_op = sje_pkg::CS_W'({1'b0, rel_tol_r});
      default:        a_op = c_r;
    endcase
    case (b_sel)
      sje_pkg::B_C:   b_op = sje_pkg::SUM_W'(c_r);
      sje_pkg::B_S:   b_op = sje_pkg::SUM_W'(s_r);
      sje_pkg::B_APP: b_op = sje_pkg::SUM_W'(d_r[pi.p]);
      sje_pkg::B_AQQ: b_op = sje_pkg::SUM_W'(d_r[pi.q]);
      sje_pkg::B_APQ: b_op = sje_pkg::SUM_W'(o_r[pi.opq]);
      sje_pkg::B_ARP: b_op = sje_pkg::SUM_W'(o_r[pi.orp]);
      sje_pkg::B_ARQ: b_op = sje_pkg::SUM_W'(o_r[pi.orq]);
      sje_pkg::B_VP:  b_op = sje_pkg::SUM_W'(v_r[mop.vk][pi.p]);
      sje_pkg::B_VQ:  b_op = sje_pkg::SUM_W'(v_r[mop.vk][pi.q]);
      sje_pkg::B_SUM: b_op = $signed(sum_r);
      default:        b_op = sje_pkg::SUM_W'(c_r);
    endcase
  end

  // Accumulate step and rounding of the accumulator.
  logic signed [sje_pkg::ACC_W-1:0] addend, acc_base, acc_add, acc_rnd;
  logic signed [sje_pkg::RES_W-1:0] res;
  always_comb begin
    addend   = mop.dbl ? (sje_pkg::ACC_W'(prod_r) <<< 1) : sje_pkg::ACC_W'(prod_r);
    acc_base = mop.first ? '0 : acc_r;
    acc_add  = mop.neg ? acc_base - addend : acc_base + addend;
    acc_rnd  = (acc_r + sje_pkg::ACC_W'(134217728)) >>> 28;
    res      = acc_rnd[sje_pkg::RES_W-1:0];
  end

  // Sort compare between neighbors j and j+1.
  logic [1:0] sj, sj1;
  logic swap;
  assign sj   = {1'b0, sort_r[0]};
  assign sj1  = sj + 2'd1;
  assign swap = d_r[sj1] < d_r[sj];

  // Free-running product register of the shared multiplier.
  always_ff @(posedge clk) begin
    prod_r <= a_op * b_op;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_sweeps_r <= 8'd50;
      rel_tol_r    <= 16'd66;
    end else if (cfg_we) begin
      case (cfg_addr)
        sje_pkg::REG_MAX_SWEEPS: max_sweeps_r <= cfg_wdata[7:0];
        sje_pkg::REG_REL_TOL:    rel_tol_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tready && (state_r != S_OUT)) out_tvalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            for (int i = 0; i < 3; i++) begin
              d_r[i] <= sje_pkg::ENT_W'($signed(in_tdata[32*i +: 32]));
              o_r[i] <= sje_pkg::ENT_W'($signed(in_tdata[32*(i+3) +: 32]));
              for (int j = 0; j < 3; j++) begin
                v_r[i][j] <= (i == j) ? 31'sd268435456 : 31'sd0;
              end
            end
            sum_r   <= in_sum;
            ph_r    <= 2'd0;
            state_r <= S_TOL;
          end
        end
        S_TOL: begin
          if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else begin
            tolsum_r <= prod_r[sje_pkg::TS_W-1:0];
            ssum_r   <= '0;
            sweeps_r <= 8'd0;
            pr_r     <= 2'd0;
            nc_r     <= 1'b0;
            k_r      <= 2'd0;
            state_r  <= (sum_r == '0) ? S_OUT : S_PAIR;
          end
        end
        S_PAIR: begin
          if (rot_need) begin
            ssum_r <= ssum_r + sje_pkg::SUM_W'(off_abs);
            iter_r <= '0;
            if (vx0 < 0) begin
              cx_r <= -vx0;
              cy_r <= -vy0;
              cz_r <= (vy0 >= 0) ? sje_pkg::PI_Q30 : -sje_pkg::PI_Q30;
            end else begin
              cx_r <= vx0;
              cy_r <= vy0;
              cz_r <= '0;
            end
            state_r <= S_VEC;
          end else if (pr_r == 2'd2) begin
            state_r <= S_SWEEP;
          end else begin
            pr_r <= pr_r + 2'd1;
          end
        end
        S_VEC: begin
          cx_r   <= cx_nxt;
          cy_r   <= cy_nxt;
          cz_r   <= cz_nxt;
          iter_r <= iter_r + IW'(1);
          if (iter_r == ITER_LAST) state_r <= S_RINIT;
        end
        S_RINIT: begin
          // Half angle, then rotate the gain-compensated unit vector.
          cx_r    <= sje_pkg::GAIN_Q30;
          cy_r    <= '0;
          cz_r    <= cz_r >>> 1;
          iter_r  <= '0;
          state_r <= S_ROT;
        end
        S_ROT: begin
          cx_r   <= cx_nxt;
          cy_r   <= cy_nxt;
          cz_r   <= cz_nxt;
          iter_r <= iter_r + IW'(1);
          if (iter_r == ITER_LAST) state_r <= S_CS;
        end
        S_CS: begin
          c_r     <= c_full[sje_pkg::CS_W-1:0];
          s_r     <= s_full[sje_pkg::CS_W-1:0];
          u_r     <= 5'd0;
          ph_r    <= 2'd0;
          state_r <= S_MAC;
        end
        S_MAC: begin
          case (ph_r)
            2'd0: ph_r <= 2'd1;
            2'd1: begin
              acc_r <= acc_add;
              ph_r  <= 2'd2;
            end
            default: begin
              ph_r <= 2'd0;
              case (mop.wb)
                sje_pkg::WB_C2:  c2_r <= res[sje_pkg::CS_W-1:0];
                sje_pkg::WB_S2:  s2_r <= res[sje_pkg::CS_W-1:0];
                sje_pkg::WB_CS:  cs_r <= res[sje_pkg::CS_W-1:0];
                sje_pkg::WB_TMP: tmp_r <= res;
                sje_pkg::WB_DQ: begin
                  d_r[pi.q]   <= sje_pkg::clamp_entry(res);
                  d_r[pi.p]   <= sje_pkg::clamp_entry(tmp_r);
                  o_r[pi.opq] <= '0;
                end
                sje_pkg::WB_ORQ: begin
                  o_r[pi.orq] <= sje_pkg::clamp_entry(res);
                  o_r[pi.orp] <= sje_pkg::clamp_entry(tmp_r);
                end
                sje_pkg::WB_VQ: begin
                  v_r[mop.vk][pi.q] <= sje_pkg::clamp_vec(res);
                  v_r[mop.vk][pi.p] <= sje_pkg::clamp_vec(tmp_r);
                end
                default: ;
              endcase
              if (u_r == sje_pkg::MOP_LAST) begin
                if (pr_r == 2'd2) begin
                  state_r <= S_SWEEP;
                end else begin
                  pr_r    <= pr_r + 2'd1;
                  state_r <= S_PAIR;
                end
              end else begin
                u_r <= u_r + 5'd1;
              end
            end
          endcase
        end
        S_SWEEP: begin
          sweeps_r <= sweeps_nxt;
          sort_r   <= 2'd0;
          if (sweep_done) begin
            state_r <= S_SORT;
          end else if (sweeps_nxt >= max_sweeps_r) begin
            nc_r    <= 1'b1;
            state_r <= S_SORT;
          end else begin
            ssum_r  <= '0;
            pr_r    <= 2'd0;
            state_r <= S_PAIR;
          end
        end
        S_SORT: begin
          // Two bubble passes over (0,1) and (1,2), swapping on strictly less.
          if (swap) begin
            d_r[sj]  <= d_r[sj1];
            d_r[sj1] <= d_r[sj];
            for (int i = 0; i < 3; i++) begin
              v_r[i][sj]  <= v_r[i][sj1];
              v_r[i][sj1] <= v_r[i][sj];
            end
          end
          sort_r <= sort_r + 2'd1;
          if (sort_r == 2'd3) begin
            k_r     <= 2'd0;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_idx_r    <= k_r;
            out_ev_r     <= sje_pkg::sat32(d_r[k_r]);
            out_vx_r     <= sje_pkg::vec_out(v_r[0][k_r]);
            out_vy_r     <= sje_pkg::vec_out(v_r[1][k_r]);
            out_vz_r     <= sje_pkg::vec_out(v_r[2][k_r]);
            out_nc_r     <= nc_r;
            out_last_r   <= (k_r == 2'd2);
            k_r          <= k_r + 2'd1;
            if (k_r == 2'd2) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Output ports.
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_vz_r, out_vy_r, out_vx_r, out_ev_r, out_idx_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_nc_r;

endmodule

@@ rtl/sje_chk.sv @@
// ----------------------------------------------------------------------------
// Jacobi eigen unit checker
// Port-level assertions on the eigen unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "symmetric3_jacobi_eigen_unit_assert.svh"

module sje_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata,
  input logic        out_tlast
);

  // A stalled output word holds.
  `SJE_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // The last marker sits on the third eigenpair only.
  `SJE_ASSERT_IMP(a_last_rank, clk, rst_n, out_tvalid, out_tlast == (out_tdata[1:0] == 2'd2))

  // The rank never takes the unused code.
  `SJE_ASSERT_IMP(a_rank_range, clk, rst_n, out_tvalid, out_tdata[1:0] != 2'd3)

  // A taken word that is not the last is followed at once by the next rank.
  `SJE_ASSERT_NXT(a_rank_step, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid && (out_tdata[1:0] == $past(out_tdata[1:0]) + 2'd1))

  // The unit is busy right after taking a matrix.
  `SJE_ASSERT_NXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)

endmodule

bind symmetric3_jacobi_eigen_unit sje_chk u_sje_chk (.*);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Jacobi eigen unit testbench
// Sends symmetric 3x3 matrices to the eigen unit and checks each eigenpair
// word against a fixed-point predictor of the rotation sweeps and the sort.
// Both sides of the stream idle at random; the registers are changed between
// phases while the unit is idle.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  NUM_RANDOM = 200;
  localparam longint ENTRY_MAX = 64'sd8589934592;
  localparam longint VECT_MAX  = 64'sd536870912;
  localparam longint PI_ANGLE  = 64'sd3373259426;
  localparam longint CORDIC_K  = 64'sd652032874;
  localparam int  STEPS = 18;

  typedef struct {
    logic [1:0]         rank;
    logic signed [31:0] eigval;
    logic [17:0]        vx;
    logic [17:0]        vy;
    logic [17:0]        vz;
    logic               nconv;
    logic               last;
  } eigenpair_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic         cfg_addr = sje_pkg::REG_MAX_SWEEPS;
  logic [15:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [87:0]  out_tdata;
  logic         out_tlast;
  logic [0:0]   out_tuser;

  eigenpair_t pending_pairs[$];
  int  error_count = 0;
  bit  quiet = 1'b0;
  int  sweep_limit = 50;
  int  tolerance = 66;

  always #5 clk = ~clk;

  symmetric3_jacobi_eigen_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  // Arctangent of 2^-i in Q.30 radians.
  function automatic longint atan_step(input int i);
    longint head[10];
    head = '{843314857, 497837829, 263043837, 133525159, 67021687,
             33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return head[i];
    if (i <= 30) return longint'(1) << (30 - i);
    return 0;
  endfunction

  function automatic longint round_shift(input longint x, input int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic longint magnitude(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  // Vectoring CORDIC: angle of (x, y), with a half-turn for negative x.
  function automatic longint vector_angle(input longint x, input longint y);
    longint z, xs, ys;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_ANGLE : -PI_ANGLE;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_step(i);
      end else begin
        x -= ys; y += xs; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  // One Jacobi rotation of pair pr on diagonal d, off-diagonal o, vectors v.
  function automatic void rotate_pair(ref longint d[3], ref longint o[3],
                                      ref longint v[9], input int pr);
    int ptab[3][5];
    int p, q, opq, orp, orq;
    longint x, y, z, xs, ys, c, s, c2, s2, cs, app, aqq, apq, arp, arq, vp, vq;
    ptab = '{'{0, 1, 0, 2, 1}, '{0, 2, 2, 0, 1}, '{1, 2, 1, 0, 2}};
    p = ptab[pr][0]; q = ptab[pr][1]; opq = ptab[pr][2];
    orp = ptab[pr][3]; orq = ptab[pr][4];
    app = d[p]; aqq = d[q]; apq = o[opq];
    // Half the angle, then cos and sin by rotation mode.
    z = vector_angle(app - aqq, 2 * apq) >>> 1;
    x = CORDIC_K;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_step(i);
      end else begin
        x += ys; y -= xs; z += atan_step(i);
      end
    end
    c = round_shift(x, 2);
    s = round_shift(y, 2);
    c2 = round_shift(c * c, 28);
    s2 = round_shift(s * s, 28);
    cs = round_shift(c * s, 28);
    d[p] = clip(round_shift(c2 * app + 2 * cs * apq + s2 * aqq, 28), ENTRY_MAX);
    d[q] = clip(round_shift(s2 * app - 2 * cs * apq + c2 * aqq, 28), ENTRY_MAX);
    o[opq] = 0;
    arp = o[orp];
    arq = o[orq];
    o[orp] = clip(round_shift(c * arp + s * arq, 28), ENTRY_MAX);
    o[orq] = clip(round_shift(c * arq - s * arp, 28), ENTRY_MAX);
    for (int k = 0; k < 3; k++) begin
      vp = v[3 * k + p];
      vq = v[3 * k + q];
      v[3 * k + p] = clip(round_shift(c * vp + s * vq, 28), VECT_MAX);
      v[3 * k + q] = clip(round_shift(c * vq - s * vp, 28), VECT_MAX);
    end
  endfunction

  // Computes the three eigenpairs of one matrix and queues them.
  function automatic void predict_eigenpairs(input logic [191:0] m);
    longint d[3], o[3], v[9], abs_sum, tol, rot_sum, a, t;
    int sweeps;
    int offsel[3];
    bit nc;
    eigenpair_t e;
    offsel = '{0, 2, 1};
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'($signed(m[32 * i +: 32]));
      o[i] = longint'($signed(m[32 * (i + 3) +: 32]));
    end
    v = '{default: 0};
    for (int i = 0; i < 3; i++) v[4 * i] = longint'(1) << 28;
    abs_sum = magnitude(d[0]) + magnitude(d[1]) + magnitude(d[2])
            + 2 * (magnitude(o[0]) + magnitude(o[1]) + magnitude(o[2]));
    tol = tolerance;
    nc = 1'b0;
    if (abs_sum > 0) begin
      sweeps = 0;
      forever begin
        rot_sum = 0;
        for (int i = 0; i < 3; i++) begin
          a = magnitude(o[offsel[i]]);
          if (a * 65536 > tol * abs_sum) begin
            rot_sum += a;
            rotate_pair(d, o, v, i);
          end
        end
        sweeps++;
        if (rot_sum * 65536 <= tol * abs_sum) break;
        if (sweeps >= sweep_limit) begin
          nc = 1'b1;
          break;
        end
      end
      // Ascending sort, swapping only on strictly smaller.
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          if (d[j + 1] < d[j]) begin
            t = d[j]; d[j] = d[j + 1]; d[j + 1] = t;
            for (int k = 0; k < 3; k++) begin
              t = v[3 * k + j]; v[3 * k + j] = v[3 * k + j + 1]; v[3 * k + j + 1] = t;
            end
          end
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      e.rank = k[1:0];
      if (d[k] > 64'sd2147483647) e.eigval = 32'sh7FFFFFFF;
      else if (d[k] < -64'sd2147483648) e.eigval = 32'sh80000000;
      else e.eigval = d[k][31:0];
      t = clip(round_shift(v[k], 12), 65536);     e.vx = t[17:0];
      t = clip(round_shift(v[3 + k], 12), 65536); e.vy = t[17:0];
      t = clip(round_shift(v[6 + k], 12), 65536); e.vz = t[17:0];
      e.nconv = nc;
      e.last = (k == 2);
      pending_pairs.push_back(e);
    end
  endfunction

  // Receiver: stalls in random bursts unless the quiet phase is on.
  initial begin
    int left;
    left = 0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_tready = 1'b1;
      end else begin
        if (left == 0) begin
          out_tready = ($urandom_range(0, 2) != 0);
          left = $urandom_range(1, 10);
        end
        left--;
      end
    end
  end

  // Checks each accepted word against the oldest expected eigenpair.
  always @(posedge clk) begin
    eigenpair_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected output word %h", out_tdata);
        error_count++;
      end else begin
        e = pending_pairs.pop_front();
        if (out_tdata[1:0] !== e.rank) begin
          $error("pair_index: expected %0d, got %0d", e.rank, out_tdata[1:0]);
          error_count++;
        end
        if (out_tdata[33:2] !== e.eigval) begin
          $error("eigenvalue: expected %0d, got %0d", e.eigval,
                 $signed(out_tdata[33:2]));
          error_count++;
        end
        if (out_tdata[51:34] !== e.vx) begin
          $error("vec_x: expected %h, got %h", e.vx, out_tdata[51:34]);
          error_count++;
        end
        if (out_tdata[69:52] !== e.vy) begin
          $error("vec_y: expected %h, got %h", e.vy, out_tdata[69:52]);
          error_count++;
        end
        if (out_tdata[87:70] !== e.vz) begin
          $error("vec_z: expected %h, got %h", e.vz, out_tdata[87:70]);
          error_count++;
        end
        if (out_tuser[0] !== e.nconv) begin
          $error("not_converged: expected %b, got %b", e.nconv, out_tuser[0]);
          error_count++;
        end
        if (out_tlast !== e.last) begin
          $error("last_pair: expected %b, got %b", e.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  // Sends one matrix word, with a random gap first unless quiet.
  task automatic send_matrix(input logic signed [31:0] a00, a11, a22, a01, a12, a02);
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 10)) @(negedge clk);
    in_tdata = {a02, a12, a01, a22, a11, a00};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_eigenpairs(in_tdata);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Waits for every expected word, then for the unit to settle.
  task automatic drain;
    while (pending_pairs.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    drain();
    cfg_addr = idx;
    cfg_wdata = val;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == sje_pkg::REG_MAX_SWEEPS) sweep_limit = val[7:0];
    else tolerance = val;
  endtask

  // Random entry at a random scale so that full range and small values mix.
  function automatic logic signed [31:0] rand_entry();
    logic signed [31:0] r;
    r = $urandom;
    return r >>> $urandom_range(0, 24);
  endfunction

  task automatic test_directed;
    send_matrix(0, 0, 0, 0, 0, 0);                         // all-zero matrix
    send_matrix(32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 0);
    send_matrix(32'sh30000, 32'sh10000, 32'sh20000, 0, 0, 0); // unsorted diagonal
    send_matrix(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);   // saturating values
    send_matrix(32'sh80000000, 32'sh80000000, 32'sh80000000,
                32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_matrix(32'sh7FFFFFFF, 32'sh80000000, 0, 32'sh7FFFFFFF, 0, 32'sh80000000);
    send_matrix(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000); // off-diagonal only
    send_matrix(32'sh10000, 32'sh20000, 0, 32'sh8000, 0, 0);  // negative app - aqq
    send_matrix(32'sh10000, 32'sh20000, 0, -32'sh8000, 0, 0);
    send_matrix(32'sh20000, 32'sh20000, 32'sh20000, 32'sh1000, -32'sh1000, 32'sh800);
    send_matrix(-1, 1, -1, 1, -1, 1);
    send_matrix(32'sh40000, -32'sh40000, 32'sh1, 32'sh55555, 32'sh2AAAA, -32'sh33333);
  endtask

  task automatic test_config_extremes;
    // Tolerance zero: rotations continue until the sweep limit.
    write_reg(sje_pkg::REG_REL_TOL, 16'd0);
    write_reg(sje_pkg::REG_MAX_SWEEPS, 16'd2);
    send_matrix(32'sh30000, 32'sh10000, -32'sh20000, 32'sh12345, 32'sh6789, -32'sh4321);
    // Converges on the last allowed sweep: one pair rotates, then nothing.
    write_reg(sje_pkg::REG_REL_TOL, 16'd66);
    send_matrix(32'sh20000, 32'sh10000, 32'sh50000, 32'sh4000, 0, 0);
    // Zero sweeps behaves as one.
    write_reg(sje_pkg::REG_MAX_SWEEPS, 16'd0);
    send_matrix(32'sh30000, 32'sh10000, 32'sh20000, 32'sh8000, 32'sh4000, 32'sh2000);
    write_reg(sje_pkg::REG_MAX_SWEEPS, 16'd1);
    write_reg(sje_pkg::REG_REL_TOL, 16'd1);
    send_matrix(32'sh30000, 32'sh10000, 32'sh20000, 32'sh8000, 32'sh4000, 32'sh2000);
    // Loosest tolerance with the longest limit.
    write_reg(sje_pkg::REG_MAX_SWEEPS, 16'd255);
    write_reg(sje_pkg::REG_REL_TOL, 16'd65535);
    send_matrix(32'sh30000, 32'sh10000, 32'sh20000, 32'sh8000, 32'sh4000, 32'sh2000);
    send_matrix(rand_entry(), rand_entry(), rand_entry(),
                rand_entry(), rand_entry(), rand_entry());
  endtask

  task automatic test_random;
    logic signed [31:0] m[6];
    write_reg(sje_pkg::REG_MAX_SWEEPS, 16'd50);
    write_reg(sje_pkg::REG_REL_TOL, 16'd66);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      // Midway, switch to another setting once the unit has drained.
      if (n == NUM_RANDOM / 2) begin
        write_reg(sje_pkg::REG_MAX_SWEEPS, 16'($urandom_range(3, 20)));
        write_reg(sje_pkg::REG_REL_TOL, 16'($urandom_range(16, 4000)));
      end
      if (n == NUM_RANDOM - 30) begin
        drain();
        quiet = 1'b1;
      end
      foreach (m[i]) m[i] = rand_entry();
      case ($urandom_range(0, 9))
        0: m = '{default: 0};
        1: begin m[3] = 0; m[4] = 0; m[5] = 0; end        // diagonal
        2: begin m[1] = m[0]; m[2] = m[0]; end            // repeated diagonal
        3: foreach (m[i]) m[i] = $urandom;                // full range
        default: ;
      endcase
      send_matrix(m[0], m[1], m[2], m[3], m[4], m[5]);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_config_extremes();
    test_random();
    drain();
    repeat (100) @(negedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #400000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
